// ===== sv/lph_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// lph_pkg
// Shared constants, request and status codes and the slot record of the
// linear probe hash table.
// ----------------------------------------------------------------------------
package lph_pkg;

    localparam int LPH_SLOTS       = 256;
    localparam int LPH_PROBE_LIMIT = 12;

    localparam int LPH_SIZE_W = 9;
    localparam int LPH_KEY_W  = 32;
    localparam int LPH_DATA_W = 32;

    localparam logic [LPH_SIZE_W-1:0] LPH_SIZE_RESET = 9'd256;
    localparam logic [31:0]           LPH_MIX_MULT   = 32'h045d9f3b;

    localparam logic [1:0] REQ_INSERT = 2'd0;
    localparam logic [1:0] REQ_REMOVE = 2'd1;
    localparam logic [1:0] REQ_LOOKUP = 2'd2;
    localparam logic [1:0] REQ_UNUSED = 2'd3;

    localparam logic [1:0] ST_OK       = 2'd0;
    localparam logic [1:0] ST_INVALID  = 2'd1;
    localparam logic [1:0] ST_NOSPACE  = 2'd2;
    localparam logic [1:0] ST_NOTFOUND = 2'd3;

    typedef struct packed {
        logic                  used;
        logic [LPH_KEY_W-1:0]  key;
        logic [LPH_DATA_W-1:0] data;
    } t_slot;

endpackage
`default_nettype wire

// ===== sv/lph_mix.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// lph_mix
// Xor-shift-multiply key mixer, one shared 32-bit multiplier used for both
// rounds, one round per cycle.
// ----------------------------------------------------------------------------
module lph_mix
    import lph_pkg::*;
(
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 i_start,
    input  wire logic [LPH_KEY_W-1:0] i_key,
    output logic                      o_done,
    output logic [LPH_KEY_W-1:0]      o_hash
);

    function automatic logic [31:0] xor_shift(input logic [31:0] x);
        return x ^ (x >> 16);
    endfunction

    logic [31:0] r_x;
    logic        r_busy;
    logic        r_pass;
    logic        r_done;
    logic [31:0] prod;

    assign prod = r_x * LPH_MIX_MULT;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_pass <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_pass <= 1'b0;
            end else if (r_busy) begin
                if (r_pass) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end else begin
                    r_pass <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_x <= xor_shift(i_key);
        end else if (r_busy) begin
            r_x <= xor_shift(prod);
        end
    end

    assign o_done = r_done;
    assign o_hash = r_x;

endmodule
`default_nettype wire

// ===== sv/lph_rem.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// lph_rem
// Restoring remainder unit: 32-bit dividend by a 9-bit divisor, two
// quotient bits per cycle.
// ----------------------------------------------------------------------------
module lph_rem
    import lph_pkg::*;
(
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  i_start,
    input  wire logic [31:0]           i_dividend,
    input  wire logic [LPH_SIZE_W-1:0] i_divisor,
    output logic                       o_done,
    output logic [LPH_SIZE_W-1:0]      o_rem
);

    localparam int BITS_PER_STEP = 2;
    localparam int STEPS         = 32 / BITS_PER_STEP;
    localparam int CNT_W         = $clog2(STEPS);

    logic [LPH_SIZE_W-1:0] r_rem;
    logic [LPH_SIZE_W-1:0] r_d;
    logic [31:0]           r_div;
    logic [CNT_W-1:0]      r_cnt;
    logic                  r_busy;
    logic                  r_done;
    logic [LPH_SIZE_W-1:0] n_rem;

    always_comb begin
        logic [LPH_SIZE_W:0] w;
        n_rem = r_rem;
        for (int i = 0; i < BITS_PER_STEP; i++) begin
            w = {n_rem, r_div[31-i]};
            if (w >= {1'b0, r_d}) begin
                w = w - {1'b0, r_d};
            end
            n_rem = w[LPH_SIZE_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + 1'b1;
                if (r_cnt == CNT_W'(STEPS - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem <= '0;
            r_d   <= i_divisor;
            r_div <= i_dividend;
        end else if (r_busy) begin
            r_rem <= n_rem;
            r_div <= r_div << BITS_PER_STEP;
        end
    end

    assign o_done = r_done;
    assign o_rem  = r_rem;

endmodule
`default_nettype wire

// ===== sv/lph_mem.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// lph_mem
// Slot memory: one write and one registered read per cycle, with a
// clearing pass over every slot after reset.
// ----------------------------------------------------------------------------
module lph_mem
    import lph_pkg::*;
#(
    parameter int SLOTS = LPH_SLOTS
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_rst_n,
    input  wire logic [$clog2(SLOTS)-1:0] i_rd_addr,
    output t_slot                         o_rd_data,
    input  wire logic                     i_we,
    input  wire logic [$clog2(SLOTS)-1:0] i_waddr,
    input  wire t_slot                    i_wdata,
    output logic                          o_clearing
);

    localparam int IW = $clog2(SLOTS);

    t_slot          r_mem [SLOTS];
    t_slot          r_rd_data;
    logic [IW-1:0]  r_clr_addr;
    logic           r_clr_busy;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr_busy <= 1'b1;
            r_clr_addr <= '0;
        end else if (r_clr_busy) begin
            r_clr_addr <= r_clr_addr + 1'b1;
            if (r_clr_addr == IW'(SLOTS - 1)) begin
                r_clr_busy <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_clr_busy) begin
            r_mem[r_clr_addr] <= '0;
        end else if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rd_data <= r_mem[i_rd_addr];
    end

    assign o_rd_data  = r_rd_data;
    assign o_clearing = r_clr_busy;

endmodule
`default_nettype wire

// ===== sv/linear_probe_hash_table.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// linear_probe_hash_table
// Insert, remove and lookup of hashed 32-bit keys in a linear probing table,
// one result per request.
// ----------------------------------------------------------------------------
// channel   direction  tdata                                     tuser
// s_axis    in         user_key[31:0] payload[63:32]             req_type[1:0]
// m_axis    out        status[1:0] found_data[33:2]              -
//                      entry_count[42:34], zero to [47:43]
// cfg       in         i_cfg_wen / i_cfg_wdata = table_size      -
//
// A request passes the mixer's two multiplier rounds, the remainder unit at
// two bits per cycle and one memory read per probe, P the number of probes
// (1 to PROBE_LIMIT), before its result is ready.
// Requests rejected before probing skip the remainder unit and the probes;
// an unused code goes straight to its result. After reset a clearing pass
// writes every slot with s_axis_tready low. A result waiting on m_axis
// holds the next result only; the next request is accepted meanwhile.
// ----------------------------------------------------------------------------
module linear_probe_hash_table
    import lph_pkg::*;
#(
    parameter int SLOTS       = LPH_SLOTS,
    parameter int PROBE_LIMIT = LPH_PROBE_LIMIT
) (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  s_axis_tvalid,
    output logic                       s_axis_tready,
    input  wire logic [63:0]           s_axis_tdata,   // user_key, payload
    input  wire logic [1:0]            s_axis_tuser,   // req_type
    output logic                       m_axis_tvalid,
    input  wire logic                  m_axis_tready,
    output logic [47:0]                m_axis_tdata,   // status, found_data, entry_count
    input  wire logic                  i_cfg_wen,
    input  wire logic [LPH_SIZE_W-1:0] i_cfg_wdata
);

    localparam int IW       = $clog2(SLOTS);
    localparam int CW       = ((IW > LPH_SIZE_W) ? IW : LPH_SIZE_W) + 1;
    localparam int SIZE_CAP = (SLOTS < 511) ? SLOTS : 511;
    localparam int PW       = $clog2(PROBE_LIMIT + 1);

    typedef enum logic [5:0] {
        S_IDLE  = 6'b000001,
        S_HASH  = 6'b000010,
        S_MOD   = 6'b000100,
        S_ISSUE = 6'b001000,
        S_PROBE = 6'b010000,
        S_DONE  = 6'b100000
    } t_state;

    t_state                 r_state, n_state;
    logic [LPH_SIZE_W-1:0]  r_table_size;
    logic [LPH_SIZE_W-1:0]  r_count, n_count;
    logic [1:0]             r_req;
    logic [LPH_DATA_W-1:0]  r_data;
    logic [LPH_KEY_W-1:0]   r_hash, n_hash;
    logic [IW-1:0]          r_idx, n_idx;
    logic [PW-1:0]          r_cnt, n_cnt;
    logic [1:0]             r_status, n_status;
    logic [LPH_DATA_W-1:0]  r_found, n_found;

    logic                   r_out_valid, n_out_valid;
    logic [1:0]             r_out_status;
    logic [LPH_DATA_W-1:0]  r_out_found;
    logic [LPH_SIZE_W-1:0]  r_out_count;
    logic                   out_load;

    logic [LPH_SIZE_W-1:0]  eff_size;
    logic                   in_xact;
    logic                   mix_done;
    logic [LPH_KEY_W-1:0]   mix_hash;
    logic                   rem_start;
    logic                   rem_done;
    logic [LPH_SIZE_W-1:0]  rem_out;
    logic [CW-1:0]          rem_w;
    logic [CW-1:0]          nxt_w;
    logic [IW-1:0]          nxt_idx;
    logic                   last_probe;
    logic                   hit;

    logic [IW-1:0]          rd_addr;
    t_slot                  rd_slot;
    logic                   mem_we;
    t_slot                  mem_wdata;
    logic                   clearing;

    always_comb begin
        if (r_table_size == '0) begin
            eff_size = LPH_SIZE_W'(1);
        end else if (32'(r_table_size) > 32'(SIZE_CAP)) begin
            eff_size = LPH_SIZE_W'(SIZE_CAP);
        end else begin
            eff_size = r_table_size;
        end
    end

    assign s_axis_tready = (r_state == S_IDLE) && !clearing;
    assign in_xact       = s_axis_tvalid && s_axis_tready;

    assign rem_w      = CW'(rem_out);
    assign nxt_w      = CW'(r_idx) + CW'(1);
    assign nxt_idx    = (nxt_w >= CW'(eff_size)) ? '0 : nxt_w[IW-1:0];
    assign last_probe = (r_cnt == PW'(PROBE_LIMIT - 1));
    assign hit        = rd_slot.used && (rd_slot.key == r_hash);

    lph_mix u_mix (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (in_xact && (s_axis_tuser != REQ_UNUSED)),
        .i_key   (s_axis_tdata[31:0]),
        .o_done  (mix_done),
        .o_hash  (mix_hash)
    );

    lph_rem u_rem (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (rem_start),
        .i_dividend (mix_hash),
        .i_divisor  (eff_size),
        .o_done     (rem_done),
        .o_rem      (rem_out)
    );

    lph_mem #(
        .SLOTS (SLOTS)
    ) u_mem (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_rd_addr  (rd_addr),
        .o_rd_data  (rd_slot),
        .i_we       (mem_we),
        .i_waddr    (r_idx),
        .i_wdata    (mem_wdata),
        .o_clearing (clearing)
    );

    always_comb begin
        n_state   = r_state;
        n_count   = r_count;
        n_hash    = r_hash;
        n_idx     = r_idx;
        n_cnt     = r_cnt;
        n_status  = r_status;
        n_found   = r_found;
        rem_start = 1'b0;
        rd_addr   = r_idx;
        mem_we    = 1'b0;
        mem_wdata = rd_slot;
        out_load  = 1'b0;

        case (r_state)
            S_IDLE: begin
                if (in_xact) begin
                    n_found  = '0;
                    n_status = ST_INVALID;
                    n_state  = (s_axis_tuser == REQ_UNUSED) ? S_DONE : S_HASH;
                end
            end
            S_HASH: begin
                if (mix_done) begin
                    n_hash  = mix_hash;
                    n_state = S_MOD;
                    if (r_req == REQ_INSERT && r_data == '0) begin
                        n_status = ST_INVALID;
                        n_state  = S_DONE;
                    end else if (r_req == REQ_INSERT && r_count >= eff_size) begin
                        n_status = ST_NOSPACE;
                        n_state  = S_DONE;
                    end else if (mix_hash == '1) begin
                        n_status = ST_INVALID;
                        n_state  = S_DONE;
                    end else begin
                        rem_start = 1'b1;
                    end
                end
            end
            S_MOD: begin
                if (rem_done) begin
                    n_idx   = rem_w[IW-1:0];
                    n_cnt   = '0;
                    n_state = S_ISSUE;
                end
            end
            S_ISSUE: begin
                n_state = S_PROBE;
            end
            S_PROBE: begin
                n_state  = S_DONE;
                n_status = ST_NOTFOUND;
                case (r_req)
                    REQ_INSERT: begin
                        if (!rd_slot.used) begin
                            mem_we    = 1'b1;
                            mem_wdata = '{used: 1'b1, key: r_hash, data: r_data};
                            n_count   = r_count + 1'b1;
                            n_status  = ST_OK;
                        end else if (last_probe) begin
                            n_status = ST_NOSPACE;
                        end else begin
                            n_state = S_PROBE;
                        end
                    end
                    REQ_REMOVE: begin
                        if (hit) begin
                            mem_we         = 1'b1;
                            mem_wdata.used = 1'b0;
                            if (r_count != '0) begin
                                n_count = r_count - 1'b1;
                            end
                            n_status = ST_OK;
                        end else if (!last_probe) begin
                            n_state = S_PROBE;
                        end
                    end
                    default: begin
                        if (hit) begin
                            n_found  = rd_slot.data;
                            n_status = ST_OK;
                        end else if (rd_slot.used && !last_probe) begin
                            n_state = S_PROBE;
                        end
                    end
                endcase
                if (n_state == S_PROBE) begin
                    n_idx   = nxt_idx;
                    n_cnt   = r_cnt + 1'b1;
                    rd_addr = nxt_idx;
                end
            end
            S_DONE: begin
                if (!r_out_valid || m_axis_tready) begin
                    out_load = 1'b1;
                    n_state  = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_comb begin
        if (out_load) begin
            n_out_valid = 1'b1;
        end else if (m_axis_tready) begin
            n_out_valid = 1'b0;
        end else begin
            n_out_valid = r_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_IDLE;
            r_count      <= '0;
            r_table_size <= LPH_SIZE_RESET;
            r_out_valid  <= 1'b0;
            r_cnt        <= '0;
        end else begin
            r_state     <= n_state;
            r_count     <= n_count;
            r_out_valid <= n_out_valid;
            r_cnt       <= n_cnt;
            if (i_cfg_wen) begin
                r_table_size <= i_cfg_wdata;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_hash   <= n_hash;
        r_idx    <= n_idx;
        r_status <= n_status;
        r_found  <= n_found;
        if (in_xact) begin
            r_req  <= s_axis_tuser;
            r_data <= s_axis_tdata[63:32];
        end
        if (out_load) begin
            r_out_status <= r_status;
            r_out_found  <= r_found;
            r_out_count  <= r_count;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {5'b0, r_out_count, r_out_found, r_out_status};

endmodule
`default_nettype wire
